>>> rtl/core/sbpdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpdb_pkg
// Types, widths, stage numbers and constant tables shared by the spectrum
// bin polar/dB core and its cells.
// ----------------------------------------------------------------------------
package sbpdb_pkg;

  // Field widths
  localparam int IN_W    = 32;
  localparam int SCALE_W = 24;
  localparam int AMP_W   = 32;
  localparam int PH_W    = 16;
  localparam int DB_W    = 17;

  // Vectoring rotator
  localparam int CORDIC_STAGES = 18;
  localparam int CX_W  = 50;  // Q15.16 input scaled by 2^16, plus gain headroom
  localparam int CZ_W  = 34;  // angle in 2^-32 turn
  localparam int SH_W  = 5;

  // Square root
  localparam int SQ_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = ROOT_W + 1;
  localparam int SQRT_CELLS = SQ_W / 2;

  // Logarithm
  localparam int V_W        = 64;
  localparam int NORM_STEPS = 6;
  localparam int CNT_W      = NORM_STEPS;
  localparam int M_W        = 31;
  localparam int FRAC_W     = 16;
  localparam int LOG_CELLS  = FRAC_W;
  localparam int LG_W       = CNT_W + FRAC_W;
  localparam int DBP_W      = 50;

  // Pipeline stage numbers, 1 is the input register
  localparam int IN_STG   = 1;
  localparam int SUM_STG  = 2;
  localparam int ROOT_STG = SUM_STG + SQRT_CELLS;
  localparam int MOD_STG  = ROOT_STG + 1;
  localparam int APR_STG  = MOD_STG + 1;
  localparam int AMP_STG  = APR_STG + 1;
  localparam int V_STG    = AMP_STG + 1;
  localparam int NORM_STG = V_STG + NORM_STEPS;
  localparam int M_STG    = NORM_STG + 1;
  localparam int LOGE_STG = M_STG + LOG_CELLS;
  localparam int N_STG    = LOGE_STG + 1;
  localparam int PH_STG   = IN_STG + CORDIC_STAGES + 1;
  localparam int AMP_DLY  = N_STG - AMP_STG;
  localparam int PH_DLY   = N_STG - PH_STG;

  // Constants
  localparam logic [CZ_W-1:0]  QUARTER_TURN = CZ_W'(64'd1073741824);
  localparam logic [35:0]      PH_OFFSET    = 36'd2147516416;  // half turn plus rounding
  localparam logic [PH_W-1:0]  PH_ZERO_BIN  = 16'd32768;
  localparam logic [PH_W-1:0]  PH_MAX       = 16'hFFFF;
  localparam logic [56:0]      AMP_ROUND    = 57'd4194304;
  localparam logic [V_W-1:0]   CRUMB_Q40    = 64'd109951;
  localparam logic [CNT_W-1:0] E_BIAS       = 6'd40;
  localparam logic signed [27:0] DB_PER_LOG2_Q24 = 28'sd101008905;
  localparam logic signed [DBP_W-1:0] DB_ROUND = 50'sd2147483648;
  localparam logic signed [DB_W-1:0]  LEVEL_FLOOR = -17'sd35840;

  // atan(2^-k) in 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
    logic                   zero;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rest;
  } sqrt_t;

  typedef struct packed {
    logic [M_W-1:0]    m;
    logic [CNT_W-1:0]  e;
    logic [FRAC_W-1:0] frac;
  } log_t;

endpackage
`default_nettype wire

>>> rtl/core/sbpdb_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpdb_cordic_cell
// One vectoring micro-rotation: drive y toward zero and accumulate the angle.
// ----------------------------------------------------------------------------
module sbpdb_cordic_cell (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic [sbpdb_pkg::SH_W-1:0]   shift_i,
  input  wire sbpdb_pkg::cordic_t           d_i,
  output sbpdb_pkg::cordic_t                q_o
);

  sbpdb_pkg::cordic_t cell_d;
  sbpdb_pkg::cordic_t cell_q;
  logic signed [sbpdb_pkg::CX_W-1:0] xs;
  logic signed [sbpdb_pkg::CX_W-1:0] ys;
  logic signed [sbpdb_pkg::CZ_W-1:0] da;

  always_comb begin
    xs = d_i.x >>> shift_i;
    ys = d_i.y >>> shift_i;
    da = signed'(sbpdb_pkg::CZ_W'(sbpdb_pkg::ATAN_TURNS[shift_i]));
    cell_d.zero = d_i.zero;
    if (d_i.y > 0) begin
      cell_d.x = d_i.x + ys;
      cell_d.y = d_i.y - xs;
      cell_d.z = d_i.z + da;
    end else begin
      cell_d.x = d_i.x - ys;
      cell_d.y = d_i.y + xs;
      cell_d.z = d_i.z - da;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/sbpdb_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpdb_sqrt_cell
// One digit of a restoring square root: bring down two radicand bits,
// try the next root bit.
// ----------------------------------------------------------------------------
module sbpdb_sqrt_cell (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire sbpdb_pkg::sqrt_t d_i,
  output sbpdb_pkg::sqrt_t      q_o
);

  sbpdb_pkg::sqrt_t cell_d;
  sbpdb_pkg::sqrt_t cell_q;
  logic [sbpdb_pkg::REM_W+1:0] acc;
  logic [sbpdb_pkg::REM_W+1:0] trial;
  logic [sbpdb_pkg::REM_W+1:0] diff;
  logic                        ge;

  always_comb begin
    acc   = {d_i.rem, d_i.rest[sbpdb_pkg::SQ_W-1 -: 2]};
    trial = {1'b0, d_i.root, 2'b01};
    ge    = (acc >= trial);
    diff  = acc - trial;
    cell_d.rem  = ge ? diff[sbpdb_pkg::REM_W-1:0] : acc[sbpdb_pkg::REM_W-1:0];
    cell_d.root = {d_i.root[sbpdb_pkg::ROOT_W-2:0], ge};
    cell_d.rest = d_i.rest << 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/sbpdb_log_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpdb_log_cell
// One fraction bit of log2: square the Q30 mantissa, renormalize.
// ----------------------------------------------------------------------------
module sbpdb_log_cell (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire sbpdb_pkg::log_t d_i,
  output sbpdb_pkg::log_t      q_o
);

  sbpdb_pkg::log_t cell_d;
  sbpdb_pkg::log_t cell_q;
  logic [2*sbpdb_pkg::M_W-1:0] sq;
  logic [sbpdb_pkg::M_W:0]     t;

  always_comb begin
    sq = (2*sbpdb_pkg::M_W)'(d_i.m) * (2*sbpdb_pkg::M_W)'(d_i.m);
    t  = sq[2*sbpdb_pkg::M_W-1 -: sbpdb_pkg::M_W+1];
    cell_d.e    = d_i.e;
    cell_d.frac = {d_i.frac[sbpdb_pkg::FRAC_W-2:0], t[sbpdb_pkg::M_W]};
    cell_d.m    = t[sbpdb_pkg::M_W] ? t[sbpdb_pkg::M_W:1] : t[sbpdb_pkg::M_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule
`default_nettype wire

>>> rtl/core/spectrum_bin_polar_db_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_bin_polar_db_core
// Complex bin to scaled amplitude, phase in turns and level in dB.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | sink      | in_valid_i / in_stall_o  | real_part_i, imag_part_i
//  out      | source    | out_valid_o / out_stall_i| amplitude_o, phase_turns_o,
//           |           |                          | level_db_o
//  cfg      | sink      | cfg_we_i                 | cfg_wdata_i (amplitude scale)
//
//  One item per cycle while the pipeline is not held by an output stall.
//  32 square-root cells, 16 log squaring cells and the amplitude and
//  normalizer stages set the pipeline depth; the rotator runs alongside.
//  Reset clears the valid line and the output valid flag; the scale resets to 2^-9.
//  Output stall holds the pipeline only when the last stage is also full.
// ----------------------------------------------------------------------------
module spectrum_bin_polar_db_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [sbpdb_pkg::SCALE_W-1:0]       cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic signed [sbpdb_pkg::IN_W-1:0]   real_part_i,
  input  wire logic signed [sbpdb_pkg::IN_W-1:0]   imag_part_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic [sbpdb_pkg::AMP_W-1:0]         amplitude_o,
  output      logic [sbpdb_pkg::PH_W-1:0]          phase_turns_o,
  output      logic signed [sbpdb_pkg::DB_W-1:0]   level_db_o
);

  localparam int NS = sbpdb_pkg::N_STG;

  logic                               pipe_en;
  logic                               vld_last;
  logic [NS-1:0]                      vld_q;
  logic [sbpdb_pkg::SCALE_W-1:0]      scale_q;

  // input stage
  logic signed [2*sbpdb_pkg::IN_W-1:0] re_sq;
  logic signed [2*sbpdb_pkg::IN_W-1:0] im_sq;
  logic signed [sbpdb_pkg::CX_W-1:0]   xr;
  logic signed [sbpdb_pkg::CX_W-1:0]   yr;
  sbpdb_pkg::cordic_t                  cord_init;
  logic [2*sbpdb_pkg::IN_W-2:0]        sqre_q;
  logic [2*sbpdb_pkg::IN_W-2:0]        sqim_q;
  logic [sbpdb_pkg::SQ_W-1:0]          sum_q;

  sbpdb_pkg::cordic_t cord_ch [sbpdb_pkg::CORDIC_STAGES+1];
  sbpdb_pkg::sqrt_t   root_ch [sbpdb_pkg::SQRT_CELLS+1];
  sbpdb_pkg::log_t    log_ch  [sbpdb_pkg::LOG_CELLS+1];

  // phase
  logic signed [35:0]                  ph_sum;
  logic [sbpdb_pkg::PH_W-1:0]          ph_d;
  logic [sbpdb_pkg::PH_W-1:0]          ph_q;
  logic [sbpdb_pkg::PH_W-1:0]          ph_dly_q [sbpdb_pkg::PH_DLY];

  // amplitude
  logic [sbpdb_pkg::ROOT_W-1:0]        mod_q;
  logic [sbpdb_pkg::ROOT_W+sbpdb_pkg::SCALE_W-1:0] aprod_q;
  logic [56:0]                         amp_rnd;
  logic [sbpdb_pkg::AMP_W-1:0]         amp_q;
  logic [sbpdb_pkg::AMP_W-1:0]         amp_dly_q [sbpdb_pkg::AMP_DLY];

  // level
  logic [sbpdb_pkg::V_W-1:0]           v_q;
  logic [sbpdb_pkg::V_W-1:0]           nw_q [sbpdb_pkg::NORM_STEPS];
  logic [sbpdb_pkg::CNT_W-1:0]         nc_q [sbpdb_pkg::NORM_STEPS];
  logic [sbpdb_pkg::M_W-1:0]           nm_q;
  logic [sbpdb_pkg::CNT_W-1:0]         ne_q;
  logic signed [sbpdb_pkg::LG_W-1:0]   lg_s;
  logic signed [sbpdb_pkg::DBP_W-1:0]  dbp_q;
  logic signed [sbpdb_pkg::DBP_W-1:0]  db_rnd;

  // output register
  logic                                out_vld_q;
  logic [sbpdb_pkg::AMP_W-1:0]         amp_out_q;
  logic [sbpdb_pkg::PH_W-1:0]          ph_out_q;
  logic signed [sbpdb_pkg::DB_W-1:0]   db_out_q;

  // Advance unless the output is held and the last stage has an item too.
  assign vld_last   = vld_q[NS-1];
  assign pipe_en    = !(out_vld_q && out_stall_i && vld_last);
  assign in_stall_o = !pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= sbpdb_pkg::SCALE_W'(16384);
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---- input stage: squares and rotator pre-rotation ----
  always_comb begin
    re_sq = real_part_i * real_part_i;
    im_sq = imag_part_i * imag_part_i;
    xr    = sbpdb_pkg::CX_W'(real_part_i) <<< 16;
    yr    = sbpdb_pkg::CX_W'(imag_part_i) <<< 16;
    cord_init.zero = (real_part_i == '0) && (imag_part_i == '0);
    cord_init.x = xr;
    cord_init.y = yr;
    cord_init.z = '0;
    // move a left half-plane vector into the right half-plane
    if (xr < 0) begin
      if (yr >= 0) begin
        cord_init.x = yr;
        cord_init.y = -xr;
        cord_init.z = signed'(sbpdb_pkg::QUARTER_TURN);
      end else begin
        cord_init.x = -yr;
        cord_init.y = xr;
        cord_init.z = -signed'(sbpdb_pkg::QUARTER_TURN);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sqre_q     <= re_sq[2*sbpdb_pkg::IN_W-2:0];
      sqim_q     <= im_sq[2*sbpdb_pkg::IN_W-2:0];
      cord_ch[0] <= cord_init;
      sum_q      <= sbpdb_pkg::SQ_W'(sqre_q) + sbpdb_pkg::SQ_W'(sqim_q);
    end
  end

  // ---- phase: rotator chain ----
  for (genvar g = 0; g < sbpdb_pkg::CORDIC_STAGES; g++) begin : g_cordic
    sbpdb_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .shift_i (sbpdb_pkg::SH_W'(g)),
      .d_i     (cord_ch[g]),
      .q_o     (cord_ch[g+1])
    );
  end

  always_comb begin
    ph_sum = 36'(cord_ch[sbpdb_pkg::CORDIC_STAGES].z) + signed'(sbpdb_pkg::PH_OFFSET);
    if (cord_ch[sbpdb_pkg::CORDIC_STAGES].zero) begin
      ph_d = sbpdb_pkg::PH_ZERO_BIN;
    end else if (ph_sum[35]) begin
      ph_d = '0;
    end else if (|ph_sum[34:32]) begin
      ph_d = sbpdb_pkg::PH_MAX;
    end else begin
      ph_d = ph_sum[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ph_q        <= ph_d;
      ph_dly_q[0] <= ph_q;
      for (int i = 1; i < sbpdb_pkg::PH_DLY; i++) begin
        ph_dly_q[i] <= ph_dly_q[i-1];
      end
    end
  end

  // ---- modulus: square-root chain ----
  assign root_ch[0] = '{rem: '0, root: '0, rest: sum_q};

  for (genvar g = 0; g < sbpdb_pkg::SQRT_CELLS; g++) begin : g_sqrt
    sbpdb_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .d_i   (root_ch[g]),
      .q_o   (root_ch[g+1])
    );
  end

  assign amp_rnd = 57'(aprod_q) + sbpdb_pkg::AMP_ROUND;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // round to nearest: bump when remainder exceeds root
      mod_q <= root_ch[sbpdb_pkg::SQRT_CELLS].root +
               sbpdb_pkg::ROOT_W'(root_ch[sbpdb_pkg::SQRT_CELLS].rem >
                                  sbpdb_pkg::REM_W'(root_ch[sbpdb_pkg::SQRT_CELLS].root));
      aprod_q <= (sbpdb_pkg::ROOT_W+sbpdb_pkg::SCALE_W)'(mod_q) *
                 (sbpdb_pkg::ROOT_W+sbpdb_pkg::SCALE_W)'(scale_q);
      amp_q <= (|amp_rnd[56:55]) ? '1 : amp_rnd[54:23];
      v_q   <= {amp_q, 24'd0} + sbpdb_pkg::CRUMB_Q40;
      amp_dly_q[0] <= amp_q;
      for (int i = 1; i < sbpdb_pkg::AMP_DLY; i++) begin
        amp_dly_q[i] <= amp_dly_q[i-1];
      end
    end
  end

  // ---- level: normalize, then log2 fraction bits ----
  for (genvar g = 0; g < sbpdb_pkg::NORM_STEPS; g++) begin : g_norm
    localparam int SH = 1 << (sbpdb_pkg::NORM_STEPS - 1 - g);
    logic [sbpdb_pkg::V_W-1:0]   src;
    logic [sbpdb_pkg::CNT_W-1:0] cnt;
    if (g == 0) begin : g_first
      assign src = v_q;
      assign cnt = '0;
    end else begin : g_next
      assign src = nw_q[g-1];
      assign cnt = nc_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        if (src[sbpdb_pkg::V_W-1 -: SH] == '0) begin
          nw_q[g] <= src << SH;
          nc_q[g] <= cnt + sbpdb_pkg::CNT_W'(SH);
        end else begin
          nw_q[g] <= src;
          nc_q[g] <= cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      nm_q <= nw_q[sbpdb_pkg::NORM_STEPS-1][sbpdb_pkg::V_W-1 -: sbpdb_pkg::M_W];
      ne_q <= sbpdb_pkg::CNT_W'(sbpdb_pkg::V_W - 1) - nc_q[sbpdb_pkg::NORM_STEPS-1];
    end
  end

  assign log_ch[0] = '{m: nm_q, e: ne_q, frac: '0};

  for (genvar g = 0; g < sbpdb_pkg::LOG_CELLS; g++) begin : g_log
    sbpdb_log_cell u_cell (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .d_i   (log_ch[g]),
      .q_o   (log_ch[g+1])
    );
  end

  assign lg_s   = signed'({log_ch[sbpdb_pkg::LOG_CELLS].e - sbpdb_pkg::E_BIAS,
                           log_ch[sbpdb_pkg::LOG_CELLS].frac});
  assign db_rnd = dbp_q + sbpdb_pkg::DB_ROUND;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dbp_q <= sbpdb_pkg::DBP_W'(lg_s) * sbpdb_pkg::DBP_W'(sbpdb_pkg::DB_PER_LOG2_Q24);
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || !out_stall_i) begin
      out_vld_q <= vld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || !out_stall_i) begin
      amp_out_q <= amp_dly_q[sbpdb_pkg::AMP_DLY-1];
      ph_out_q  <= ph_dly_q[sbpdb_pkg::PH_DLY-1];
      db_out_q  <= db_rnd[32 +: sbpdb_pkg::DB_W];
    end
  end

  assign out_valid_o   = out_vld_q;
  assign amplitude_o   = amp_out_q;
  assign phase_turns_o = ph_out_q;
  assign level_db_o    = db_out_q;

  // ---- assertions ----
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("input stalled while output register was not held full");

  a_norm_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[sbpdb_pkg::M_STG-1] |-> nm_q[sbpdb_pkg::M_W-1])
    else $error("log mantissa not normalized");

  a_zero_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (amplitude_o == '0)) |-> (level_db_o == sbpdb_pkg::LEVEL_FLOOR))
    else $error("zero amplitude did not give the level floor");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_last && !pipe_en) |=> vld_last)
    else $error("item dropped from last stage while held");

endmodule
`default_nettype wire
